/* rtl/core/clr_pkg.sv */
// ----------------------------------------------------------------------------
// clr_pkg: shared types and constants for the coalescing error log ring
// Holds ring geometry, payload structs, opcode and sequencer state codes,
// and the small index helpers used by the core.
// ----------------------------------------------------------------------------
package clr_pkg;

    // Geometry
    localparam int RING_DEPTH    = 16;
    localparam int NUM_ERROR_IDS = 256;

    // Field widths
    localparam int ERR_ID_W = 8;
    localparam int FREQ_W   = 16;
    localparam int TIME_W   = 32;

    // Derived widths
    localparam int SLOT_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W    = $clog2(RING_DEPTH + 1);
    localparam int ID_W     = $clog2(NUM_ERROR_IDS);
    localparam int ID_EXT_W = ((ID_W > ERR_ID_W) ? ID_W : ERR_ID_W) + 1;

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_SEND   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_SCAN,
        S_SRCH,
        S_APPEND,
        S_DONE
    } state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [ERR_ID_W-1:0] report_id;
        logic [TIME_W-1:0]   timestamp;
    } cmd_t;

    typedef struct packed {
        logic                sent_valid;
        logic [ERR_ID_W-1:0] sent_error_id;
        logic [FREQ_W-1:0]   sent_frequency;
        logic [TIME_W-1:0]   sent_time;
        logic [FREQ_W-1:0]   overflow_count;
        logic                ring_empty;
    } rsp_t;

    typedef struct packed {
        logic [ERR_ID_W-1:0] id;
        logic [FREQ_W-1:0]   freq;
        logic [TIME_W-1:0]   stamp;
    } ring_entry_t;

    // Ring index advance with wrap
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
        return (i == SLOT_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // Number of entries held in the ring
    function automatic logic [CNT_W-1:0] fill_level(
        input logic              empty,
        input logic [SLOT_W-1:0] head,
        input logic [SLOT_W-1:0] tail
    );
        logic [CNT_W-1:0] lvl;
        if (empty)
        begin
            lvl = '0;
        end
        else if (tail == head)
        begin
            lvl = CNT_W'(RING_DEPTH);
        end
        else if (tail > head)
        begin
            lvl = CNT_W'(tail) - CNT_W'(head);
        end
        else
        begin
            lvl = CNT_W'(RING_DEPTH) - CNT_W'(head) + CNT_W'(tail);
        end
        return lvl;
    endfunction

endpackage

/* rtl/core/clr_ram.sv */
// ----------------------------------------------------------------------------
// clr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module clr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/coalescing_error_log_ring_core.sv */
// Report and no-op go from idle to done, where the result is registered; send
// reads the head entry, pops it in the send state, then goes to done. Update scans
//   every id (NUM_ERROR_IDS); each pending id searches up to RING_DEPTH ring entries
//   and appends on a miss. One item at a time: the next item is accepted once done
//   has registered the result. The id scan and the ring RAM read port set update time.
// Reset clears pending bits, indexes and counters at once; no clearing pass.
// ----------------------------------------------------------------------------
// coalescing_error_log_ring_core: coalescing error recorder with ring log
// Reports mark error ids pending; an update folds pending ids into a ring
// of entries (count hits, append misses, drop oldest when full); a send
// pops the oldest entry together with the overflow count.
// ----------------------------------------------------------------------------
module coalescing_error_log_ring_core
    import clr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Control state
    state_t                   state_reg, state_next;
    opcode_t                  op_reg, op_next;
    logic [NUM_ERROR_IDS-1:0] pending_reg, pending_next;
    logic [SLOT_W-1:0]        head_reg, head_next;
    logic [SLOT_W-1:0]        tail_reg, tail_next;
    logic                     empty_reg, empty_next;
    logic [FREQ_W-1:0]        dropped_reg, dropped_next;
    logic [ID_W-1:0]          id_cnt_reg, id_cnt_next;
    logic [SLOT_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    // Payload state
    logic [TIME_W-1:0]        ts_reg, ts_next;
    ring_entry_t              sent_reg, sent_next;
    logic                     sent_valid_reg, sent_valid_next;
    logic [FREQ_W-1:0]        ovf_reg, ovf_next;
    rsp_t                     rsp_reg, rsp_next;

    // Ring RAM port
    logic                     ram_we;
    logic [SLOT_W-1:0]        ram_waddr;
    ring_entry_t              ram_wdata;
    logic [SLOT_W-1:0]        ram_raddr;
    ring_entry_t              ram_rdata;

    // Shared decode
    logic                     cmd_fire;
    logic [CNT_W-1:0]         fill;
    logic [ID_EXT_W-1:0]      rpt_id_ext;
    logic [ID_EXT_W-1:0]      scan_id_ext;
    logic [ERR_ID_W-1:0]      scan_id8;
    logic                     scan_pend;
    logic                     last_id;
    logic                     hit;
    logic                     srch_end;
    logic                     ring_full;
    logic                     rsp_free;

    clr_ram #(
        .WIDTH ($bits(ring_entry_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ready   = (state_reg == S_IDLE);
    assign cmd_fire    = cmd_valid && cmd_ready;
    assign fill        = fill_level(empty_reg, head_reg, tail_reg);
    assign rpt_id_ext  = ID_EXT_W'(cmd.report_id);
    assign scan_id_ext = ID_EXT_W'(id_cnt_reg);
    assign scan_id8    = scan_id_ext[ERR_ID_W-1:0];
    assign scan_pend   = pending_reg[id_cnt_reg];
    assign last_id     = (id_cnt_reg == ID_W'(NUM_ERROR_IDS - 1));
    assign hit         = (ram_rdata.id == scan_id8);
    assign srch_end    = ((k_reg + 1'b1) == fill);
    assign ring_full   = !empty_reg && (tail_reg == head_reg);
    assign rsp_free    = !rsp_valid_reg || rsp_ready;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.opcode)
                        OP_UPDATE: state_next = S_SCAN;
                        OP_SEND:   state_next = empty_reg ? S_DONE : S_SEND;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_SEND:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (scan_pend)
                begin
                    state_next = (fill == '0) ? S_APPEND : S_SRCH;
                end
                else if (last_id)
                begin
                    state_next = S_DONE;
                end
            end
            S_SRCH:
            begin
                if (hit)
                begin
                    state_next = last_id ? S_DONE : S_SCAN;
                end
                else if (srch_end)
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                state_next = last_id ? S_DONE : S_SCAN;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        op_next         = op_reg;
        pending_next    = pending_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        empty_next      = empty_reg;
        dropped_next    = dropped_reg;
        id_cnt_next     = id_cnt_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        ts_next         = ts_reg;
        sent_next       = sent_reg;
        sent_valid_next = sent_valid_reg;
        ovf_next        = ovf_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;

        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_wdata.id    = scan_id8;
        ram_wdata.freq  = FREQ_W'(1);
        ram_wdata.stamp = ts_reg;
        ram_raddr       = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next         = cmd.opcode;
                    ts_next         = cmd.timestamp;
                    sent_next       = '0;
                    sent_valid_next = 1'b0;
                    id_cnt_next     = '0;
                    if ((cmd.opcode == OP_REPORT) &&
                        (rpt_id_ext < ID_EXT_W'(NUM_ERROR_IDS)))
                    begin
                        pending_next[rpt_id_ext[ID_W-1:0]] = 1'b1;
                    end
                end
            end
            S_SEND:
            begin
                // Pop the head entry read in the previous cycle
                sent_next       = ram_rdata;
                sent_valid_next = 1'b1;
                ovf_next        = dropped_reg;
                dropped_next    = '0;
                head_next       = next_slot(head_reg);
                if (next_slot(head_reg) == tail_reg)
                begin
                    empty_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (scan_pend)
                begin
                    pos_next  = head_reg;
                    k_next    = '0;
                    ram_raddr = head_reg;
                end
                else if (!last_id)
                begin
                    id_cnt_next = id_cnt_reg + 1'b1;
                end
            end
            S_SRCH:
            begin
                if (hit)
                begin
                    // Existing entry: bump its count in place
                    ram_we          = 1'b1;
                    ram_waddr       = pos_reg;
                    ram_wdata       = ram_rdata;
                    if (ram_rdata.freq != FREQ_MAX)
                    begin
                        ram_wdata.freq = ram_rdata.freq + 1'b1;
                    end
                    pending_next[id_cnt_reg] = 1'b0;
                    if (!last_id)
                    begin
                        id_cnt_next = id_cnt_reg + 1'b1;
                    end
                end
                else if (!srch_end)
                begin
                    pos_next  = next_slot(pos_reg);
                    k_next    = k_reg + 1'b1;
                    ram_raddr = next_slot(pos_reg);
                end
            end
            S_APPEND:
            begin
                // New entry at tail; a full ring drops its oldest entry
                ram_we = 1'b1;
                if (ring_full)
                begin
                    head_next = next_slot(head_reg);
                    if (dropped_reg != FREQ_MAX)
                    begin
                        dropped_next = dropped_reg + 1'b1;
                    end
                end
                tail_next  = next_slot(tail_reg);
                empty_next = 1'b0;
                pending_next[id_cnt_reg] = 1'b0;
                if (!last_id)
                begin
                    id_cnt_next = id_cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.sent_valid     = sent_valid_reg;
                    rsp_next.sent_error_id  = sent_reg.id;
                    rsp_next.sent_frequency = sent_reg.freq;
                    rsp_next.sent_time      = sent_reg.stamp;
                    rsp_next.overflow_count = sent_valid_reg ? ovf_reg : dropped_reg;
                    rsp_next.ring_empty     = empty_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NOP;
            pending_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            dropped_reg   <= '0;
            id_cnt_reg    <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            pending_reg   <= pending_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            dropped_reg   <= dropped_next;
            id_cnt_reg    <= id_cnt_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ts_reg         <= ts_next;
        sent_reg       <= sent_next;
        sent_valid_reg <= sent_valid_next;
        ovf_reg        <= ovf_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // Empty ring always has matching indexes
    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == tail_reg))
        else $error("ring empty with head and tail apart");

    // The search never walks past the filled part of the ring
    a_srch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (k_reg < fill))
        else $error("ring search beyond fill level");

    // An update leaves no pending id behind
    a_update_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (op_reg == OP_UPDATE)) |-> (pending_reg == '0))
        else $error("pending bits left after update");

    // A pop leaves the ring one entry shorter
    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) |=> (fill == $past(fill) - 1'b1))
        else $error("send did not remove exactly one entry");
`endif

endmodule
